/* rtl/core/vtp_pkg.sv */
// Package with shared types and constants for the vertex transform block.
`timescale 1ns / 1ps
package vtp_pkg;

    localparam int CoordWidth = 16;
    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth = 48;
    localparam int CenterWidth = 10;
    localparam logic [CenterWidth-1:0] CenterReset = 10'd88;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_ROW_X = 3'd0,
        REG_ROW_Y = 3'd1,
        REG_ROW_Z = 3'd2,
        REG_TRANS = 3'd3,
        REG_CTR_X = 3'd4,
        REG_CTR_Y = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [CoordWidth-1:0] vertex_x;
        logic signed [CoordWidth-1:0] vertex_y;
        logic signed [CoordWidth-1:0] vertex_z;
    } vertex_t;

    typedef struct packed {
        logic signed [CoordWidth-1:0] screen_x;
        logic signed [CoordWidth-1:0] screen_y;
        logic signed [CoordWidth-1:0] depth;
        logic                         divide_fault;
    } result_t;

    typedef struct packed {
        logic [CfgIndexWidth-1:0] index;
        logic [CfgDataWidth-1:0]  data;
    } cfg_write_t;

endpackage

/* rtl/core/vtp_if.sv */
// Valid/ready stream interface used by all channels of the block.
`timescale 1ns / 1ps
interface vtp_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/vtp_divider.sv */
// Pipelined signed restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module vtp_divider #(
    parameter int NumWidth = 40,
    parameter int DenWidth = 16,
    parameter int TagWidth = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  logic [NumWidth-1:0] in_num,
    input  logic [DenWidth-1:0] in_den,
    input  logic [TagWidth-1:0] in_tag,
    output logic                out_valid,
    output logic [NumWidth-1:0] out_quot,
    output logic                out_neg,
    output logic [TagWidth-1:0] out_tag
);
    // Operands are reduced to magnitudes here; the quotient sign is applied by the caller.
    localparam int Stages = NumWidth;

    logic [NumWidth-1:0] rem_reg  [Stages+1];
    logic [NumWidth-1:0] quo_reg  [Stages+1];
    logic [DenWidth-1:0] den_reg  [Stages+1];
    logic [TagWidth-1:0] tag_reg  [Stages+1];
    logic                neg_reg  [Stages+1];
    logic                vld_reg  [Stages+1];

    logic                num_neg;
    logic                den_neg;
    logic [NumWidth-1:0] num_mag;
    logic [DenWidth-1:0] den_mag;

    always_comb
    begin
        num_neg = in_num[NumWidth-1];
        den_neg = in_den[DenWidth-1];
        num_mag = num_neg ? (~in_num + 1'b1) : in_num;
        den_mag = den_neg ? (~in_den + 1'b1) : in_den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0] <= '0;
            quo_reg[0] <= num_mag;
            den_reg[0] <= den_mag;
            tag_reg[0] <= in_tag;
            neg_reg[0] <= num_neg ^ den_neg;
        end
    end

    for (genvar s = 0; s < Stages; s++)
    begin : g_stage
        logic [NumWidth:0]   trial;
        logic [NumWidth-1:0] shifted;
        always_comb
        begin
            shifted = {rem_reg[s][NumWidth-2:0], quo_reg[s][NumWidth-1]};
            trial   = {1'b0, shifted} - {{(NumWidth+1-DenWidth){1'b0}}, den_reg[s]};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[s+1] <= trial[NumWidth] ? shifted : trial[NumWidth-1:0];
                quo_reg[s+1] <= {quo_reg[s][NumWidth-2:0], ~trial[NumWidth]};
                den_reg[s+1] <= den_reg[s];
                tag_reg[s+1] <= tag_reg[s];
                neg_reg[s+1] <= neg_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[Stages];
    assign out_quot  = quo_reg[Stages];
    assign out_neg   = neg_reg[Stages];
    assign out_tag   = tag_reg[Stages];
endmodule

/* rtl/core/vertex_transform_project_top.sv */
// Top level of the vertex transform and perspective projection pipeline.
`timescale 1ns / 1ps
// One vertex enters per cycle while the pipe advances, and gives one result. The pipe
// has three transform stages (input register, products, row sums), the divider
// input register, one divider stage per dividend bit (36 + PROJECTION_SHIFT, 44 by
// default) and the output register, and a result is presented once its vertex beat
// has passed through all of them. The whole pipe advances together and holds when
// the output register is full and not taken.
module vertex_transform_project_top #(
    parameter int FRACTION_BITS = 12,
    parameter int PROJECTION_SHIFT = 8
) (
    input logic clk,
    input logic rst_n,
    vtp_if.sink   vertex,
    vtp_if.source result,
    vtp_if.sink   cfg
);
    import vtp_pkg::*;

    // Row sum: (a+y)(b+x) 34 bits, c*z 32, x*y 32; total fits in 36 bits.
    localparam int SumWidth = 36;
    localparam int RowWidth = 36;
    localparam int NumWidth = RowWidth + PROJECTION_SHIFT;
    localparam int TagWidth = 3 * CoordWidth;

    logic [CfgDataWidth-1:0] row_x_reg, row_y_reg, row_z_reg, trans_reg;
    logic [CenterWidth-1:0]  ctr_x_reg, ctr_y_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg <= '0;
            row_y_reg <= '0;
            row_z_reg <= '0;
            trans_reg <= '0;
            ctr_x_reg <= CenterReset;
            ctr_y_reg <= CenterReset;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                REG_ROW_X: row_x_reg <= cfg.payload.data;
                REG_ROW_Y: row_y_reg <= cfg.payload.data;
                REG_ROW_Z: row_z_reg <= cfg.payload.data;
                REG_TRANS: trans_reg <= cfg.payload.data;
                REG_CTR_X: ctr_x_reg <= cfg.payload.data[CenterWidth-1:0];
                REG_CTR_Y: ctr_y_reg <= cfg.payload.data[CenterWidth-1:0];
                default: ;
            endcase
        end
    end

    logic advance;
    logic out_valid_reg;
    assign advance      = !out_valid_reg || result.ready;
    assign vertex.ready = advance;

    // Stage 1: register inputs.
    logic                         s1_vld_reg;
    logic signed [CoordWidth-1:0] s1_x_reg, s1_y_reg, s1_z_reg;
    // Stage 2: per-row products.
    logic                         s2_vld_reg;
    logic signed [SumWidth-1:0]   s2_p1_reg [3];
    logic signed [SumWidth-1:0]   s2_p2_reg [3];
    logic signed [SumWidth-1:0]   s2_ab_reg [3];
    logic signed [SumWidth-1:0]   s2_xy_reg;
    // Stage 3: row sums, shifted.
    logic                         s3_vld_reg;
    logic signed [RowWidth-1:0]   s3_row_reg [3];

    logic [CfgDataWidth-1:0] coef [3];
    assign coef[0] = row_x_reg;
    assign coef[1] = row_y_reg;
    assign coef[2] = row_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_vld_reg <= vertex.valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_x_reg  <= vertex.payload.vertex_x;
            s1_y_reg  <= vertex.payload.vertex_y;
            s1_z_reg  <= vertex.payload.vertex_z;
            s2_xy_reg <= SumWidth'(s1_x_reg * s1_y_reg);
        end
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        logic signed [CoordWidth-1:0] a, b, c, t;
        logic signed [CoordWidth:0]   ay, bx;
        logic signed [SumWidth-1:0]   sum;
        always_comb
        begin
            a   = coef[r][15:0];
            b   = coef[r][31:16];
            c   = coef[r][47:32];
            t   = trans_reg[16*r +: 16];
            ay  = (CoordWidth+1)'(a) + (CoordWidth+1)'(s1_y_reg);
            bx  = (CoordWidth+1)'(b) + (CoordWidth+1)'(s1_x_reg);
            sum = s2_p1_reg[r] + s2_p2_reg[r] - s2_xy_reg;
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                s2_p1_reg[r]  <= SumWidth'(ay * bx);
                s2_p2_reg[r]  <= SumWidth'(c * s1_z_reg);
                s2_ab_reg[r]  <= SumWidth'(a * b)
                                 - SumWidth'(t) * SumWidth'(1 << FRACTION_BITS);
                s3_row_reg[r] <= (sum >>> FRACTION_BITS)
                                 - (s2_ab_reg[r] >>> FRACTION_BITS);
            end
        end
    end

    // The translation is folded into the a*b term: asr(ab - t*2^F) = asr(ab) - t.
    logic signed [CoordWidth-1:0] d3;
    logic signed [NumWidth-1:0]   num_x, num_y;
    assign d3    = s3_row_reg[2][CoordWidth-1:0];
    assign num_x = NumWidth'(s3_row_reg[0]) <<< PROJECTION_SHIFT;
    assign num_y = NumWidth'(s3_row_reg[1]) <<< PROJECTION_SHIFT;

    logic              dx_vld, dy_vld, dx_neg, dy_neg;
    logic [NumWidth-1:0] qx, qy;
    logic [TagWidth-1:0] tag_x, tag_y;

    vtp_divider #(.NumWidth(NumWidth), .DenWidth(CoordWidth), .TagWidth(TagWidth)) u_div_x (
        .clk(clk), .rst_n(rst_n), .advance(advance), .in_valid(s3_vld_reg),
        .in_num(num_x), .in_den(d3),
        .in_tag({d3, {(CoordWidth-1){1'b0}}, num_x[NumWidth-1], {CoordWidth{1'b0}}}),
        .out_valid(dx_vld), .out_quot(qx), .out_neg(dx_neg), .out_tag(tag_x));

    vtp_divider #(.NumWidth(NumWidth), .DenWidth(CoordWidth), .TagWidth(TagWidth)) u_div_y (
        .clk(clk), .rst_n(rst_n), .advance(advance), .in_valid(s3_vld_reg),
        .in_num(num_y), .in_den(d3),
        .in_tag({d3, {(CoordWidth-1){1'b0}}, num_y[NumWidth-1], {CoordWidth{1'b0}}}),
        .out_valid(dy_vld), .out_quot(qy), .out_neg(dy_neg), .out_tag(tag_y));

    function automatic logic [CoordWidth:0] sat_quot(
        input logic [NumWidth-1:0] mag, input logic neg, input logic num_neg,
        input logic zero_den);
        logic [CoordWidth:0] res;
        logic                big;
        begin
            big = neg ? (mag > NumWidth'(32768)) : (mag > NumWidth'(32767));
            if (zero_den)
                res = {1'b1, num_neg ? 16'h8000 : 16'h7FFF};
            else if (big)
                res = {1'b1, neg ? 16'h8000 : 16'h7FFF};
            else
                res = {1'b0, neg ? 16'(~mag[CoordWidth-1:0] + 1'b1) : mag[CoordWidth-1:0]};
            return res;
        end
    endfunction

    function automatic logic [CoordWidth-1:0] add_ctr(
        input logic [CoordWidth-1:0] q, input logic [CenterWidth-1:0] ctr);
        logic signed [CoordWidth:0] s;
        begin
            s = (CoordWidth+1)'($signed(q)) + (CoordWidth+1)'({1'b0, ctr});
            if (s > 17'sd32767)
                return 16'h7FFF;
            return s[CoordWidth-1:0];
        end
    endfunction

    logic                zero_den;
    logic [CoordWidth:0] sq_x, sq_y;
    assign zero_den = (tag_x[TagWidth-1 -: CoordWidth] == '0);
    assign sq_x = sat_quot(qx, dx_neg, tag_x[CoordWidth], zero_den);
    assign sq_y = sat_quot(qy, dy_neg, tag_y[CoordWidth], zero_den);

    result_t out_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= dx_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.screen_x     <= add_ctr(sq_x[CoordWidth-1:0], ctr_x_reg);
            out_reg.screen_y     <= add_ctr(sq_y[CoordWidth-1:0], ctr_y_reg);
            out_reg.depth        <= tag_x[TagWidth-1 -: CoordWidth];
            out_reg.divide_fault <= sq_x[CoordWidth] | sq_y[CoordWidth];
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    // The two dividers run in lockstep.
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        dx_vld == dy_vld) else $error("divider lanes out of step");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg && $stable(out_reg))
        else $error("result lost under stall");
    a_zero_fault: assert property (@(posedge clk) disable iff (!rst_n)
        advance && dx_vld && zero_den |=> out_reg.divide_fault)
        else $error("zero depth without fault");
endmodule

/* verif/vtp_checker.sv */
// Checker that predicts and compares the results of the vertex transform block.
`timescale 1ns / 1ps
module vtp_checker #(
    parameter int FRACTION_BITS = 12,
    parameter int PROJECTION_SHIFT = 8
) (
    input  logic clk,
    input  logic rst_n,
    vtp_if       vertex,
    vtp_if       result,
    vtp_if       cfg,
    output int   fail_count,
    output int   pending
);
    import vtp_pkg::*;

    logic [CfgDataWidth-1:0] row_x;
    logic [CfgDataWidth-1:0] row_y;
    logic [CfgDataWidth-1:0] row_z;
    logic [CfgDataWidth-1:0] offsets;
    logic [CenterWidth-1:0]  center_x;
    logic [CenterWidth-1:0]  center_y;
    result_t                 expected_screen[$];

    function automatic longint lane(logic [CfgDataWidth-1:0] word, int k);
        logic signed [CoordWidth-1:0] part;
        part = word[16*k +: 16];
        return longint'(part);
    endfunction

    function automatic longint transform_row(logic [CfgDataWidth-1:0] coeffs, longint t,
                                             longint x, longint y, longint z);
        longint a;
        longint b;
        longint c;
        longint s;
        a = lane(coeffs, 0);
        b = lane(coeffs, 1);
        c = lane(coeffs, 2);
        s = (a + y) * (b + x) + c * z - x * y;
        return (s >>> FRACTION_BITS) + t - ((a * b) >>> FRACTION_BITS);
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint perspective(longint coord, longint d, inout logic fault);
        longint num;
        longint q;
        num = coord * (longint'(1) <<< PROJECTION_SHIFT);
        if (d == 0)
        begin
            fault = 1'b1;
            return (num < 0) ? -32768 : 32767;
        end
        // Integer division of longints truncates toward zero.
        q = num / d;
        if (q > 32767 || q < -32768)
            fault = 1'b1;
        return clamp16(q);
    endfunction

    function automatic result_t project_vertex(vertex_t v);
        longint  x;
        longint  y;
        longint  z;
        longint  xp;
        longint  yp;
        longint  zp;
        longint  d;
        logic    fault;
        result_t r;
        logic signed [CoordWidth-1:0] depth16;
        x = longint'(v.vertex_x);
        y = longint'(v.vertex_y);
        z = longint'(v.vertex_z);
        xp = transform_row(row_x, lane(offsets, 0), x, y, z);
        yp = transform_row(row_y, lane(offsets, 1), x, y, z);
        zp = transform_row(row_z, lane(offsets, 2), x, y, z);
        depth16 = zp[15:0];
        d = longint'(depth16);
        fault = 1'b0;
        r.screen_x = 16'(clamp16(perspective(xp, d, fault) + longint'(center_x)));
        r.screen_y = 16'(clamp16(perspective(yp, d, fault) + longint'(center_y)));
        r.depth = depth16;
        r.divide_fault = fault;
        return r;
    endfunction

    function automatic int report(string field, longint exp_val, longint act_val);
        if (exp_val == act_val)
            return 0;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
        return 1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        result_t act_r;
        int      errs;
        if (!rst_n)
        begin
            row_x <= '0;
            row_y <= '0;
            row_z <= '0;
            offsets <= '0;
            center_x <= CenterReset;
            center_y <= CenterReset;
            fail_count <= 0;
            pending <= 0;
            expected_screen.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.payload.index)
                    REG_ROW_X: row_x <= cfg.payload.data;
                    REG_ROW_Y: row_y <= cfg.payload.data;
                    REG_ROW_Z: row_z <= cfg.payload.data;
                    REG_TRANS: offsets <= cfg.payload.data;
                    REG_CTR_X: center_x <= cfg.payload.data[CenterWidth-1:0];
                    REG_CTR_Y: center_y <= cfg.payload.data[CenterWidth-1:0];
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                act_r = result.payload;
                if (expected_screen.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %p", $time, act_r);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_screen.pop_front();
                    errs = report("screen_x", exp_r.screen_x, act_r.screen_x)
                         + report("screen_y", exp_r.screen_y, act_r.screen_y)
                         + report("depth", exp_r.depth, act_r.depth)
                         + report("divide_fault", exp_r.divide_fault, act_r.divide_fault);
                    if (errs != 0)
                        fail_count <= fail_count + 1;
                end
            end
            if (vertex.valid && vertex.ready)
                expected_screen.push_back(project_vertex(vertex.payload));
            pending <= expected_screen.size();
        end
    end
endmodule

/* verif/tb.sv */
// Top of the testbench: clock, reset, stimulus and verdict for the vertex transform block.
`timescale 1ns / 1ps
module tb;
    import vtp_pkg::*;

    localparam int FractionBits = 12;
    localparam int ProjectionShift = 8;
    localparam int DrainCycles = 40;
    localparam int CycleLimit = 300000;
    localparam int PhaseItems = 125;
    localparam logic [CfgIndexWidth-1:0] RegUnused = 3'd6;
    localparam logic [CfgIndexWidth-1:0] RegTopIndex = 3'd7;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycles;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   vertex_count;
    int   config_count;

    vtp_if #(.payload_t(vertex_t))    vertex_ch ();
    vtp_if #(.payload_t(result_t))    result_ch ();
    vtp_if #(.payload_t(cfg_write_t)) cfg_ch ();

    vertex_transform_project_top #(
        .FRACTION_BITS(FractionBits),
        .PROJECTION_SHIFT(ProjectionShift)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .vertex(vertex_ch),
        .result(result_ch),
        .cfg(cfg_ch)
    );

    vtp_checker #(
        .FRACTION_BITS(FractionBits),
        .PROJECTION_SHIFT(ProjectionShift)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .vertex(vertex_ch),
        .result(result_ch),
        .cfg(cfg_ch),
        .fail_count(fail_count),
        .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

    function automatic logic [15:0] pick16();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4, 5: return 16'($urandom_range(511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_coeff();
        if ($urandom_range(3) == 0)
            return pick16();
        return 16'($urandom_range(8191)) - 16'd4096;
    endfunction

    task automatic write_reg(logic [CfgIndexWidth-1:0] index, logic [CfgDataWidth-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload <= '{index: index, data: data};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        config_count++;
    endtask

    // The checker's count is registered and lags the handshake, so look only after the next edge.
    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            vertex_ch.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        vertex_ch.valid <= 1'b1;
        vertex_ch.payload <= '{vertex_x: x, vertex_y: y, vertex_z: z};
        @(posedge clk);
        while (!vertex_ch.ready)
            @(posedge clk);
        vertex_count++;
    endtask

    task automatic configure(int style);
        logic [CfgDataWidth-1:0] rows[3];
        logic [CfgDataWidth-1:0] shift_word;
        logic [CfgDataWidth-1:0] cx;
        logic [CfgDataWidth-1:0] cy;
        for (int r = 0; r < 3; r++)
        begin
            case (style)
                1: rows[r] = {3{16'h7FFF}};
                2: rows[r] = {3{16'h8000}};
                default: rows[r] = {pick_coeff(), pick_coeff(), pick_coeff()};
            endcase
        end
        case (style)
            1:
            begin
                shift_word = {3{16'h7FFF}};
                cx = 48'd1023;
                cy = 48'd0;
            end
            2:
            begin
                shift_word = {3{16'h8000}};
                cx = 48'd0;
                cy = 48'd1023;
            end
            default:
            begin
                // Keep the depth mostly away from zero so quotients stay in range.
                shift_word = {16'($urandom_range(4000, 200)), pick16(), pick16()};
                cx = 48'({$urandom, $urandom});
                cy = 48'({$urandom, $urandom});
            end
        endcase
        if (style == 0)
            rows[2][47:32] = 16'($urandom_range(1024));
        write_reg(REG_ROW_X, rows[0]);
        write_reg(REG_ROW_Y, rows[1]);
        write_reg(REG_ROW_Z, rows[2]);
        write_reg(REG_TRANS, shift_word);
        write_reg(REG_CTR_X, cx);
        write_reg(REG_CTR_Y, cy);
        write_reg(($urandom_range(1) != 0) ? RegUnused : RegTopIndex,
                  48'({$urandom, $urandom}));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cycles = 0;
        vertex_count = 0;
        config_count = 0;
        tx_idle_pct = 17;
        rx_idle_pct = 74;
        vertex_ch.valid = 1'b0;
        vertex_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: the all-zero transform gives zero depth for every vertex,
        // which covers the zero-depth fault and the saturated centre sum.
        send_vertex(16'h0000, 16'h0000, 16'h0000);
        send_vertex(16'h7FFF, 16'h8000, 16'h7FFF);
        send_vertex(16'h8000, 16'h7FFF, 16'h8000);
        send_vertex(16'hFFFF, 16'h0001, 16'hFFFF);
        vertex_ch.valid <= 1'b0;
        drain();

        // Small depth with large coordinates overflows the quotient.
        write_reg(REG_ROW_X, {16'd0, 16'd0, 16'h1000});
        write_reg(REG_ROW_Y, {16'd0, 16'd0, 16'hF000});
        write_reg(REG_ROW_Z, {16'd0, 16'd0, 16'd0});
        write_reg(REG_TRANS, {16'd1, 16'h7FFF, 16'h8000});
        write_reg(REG_CTR_X, 48'd1023);
        write_reg(REG_CTR_Y, 48'd0);
        for (int i = 0; i < 6; i++)
            send_vertex(pick16(), pick16(), pick16());
        send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_vertex(16'h8000, 16'h8000, 16'h8000);
        vertex_ch.valid <= 1'b0;
        drain();

        configure(1);
        for (int i = 0; i < 5; i++)
            send_vertex(pick16(), pick16(), pick16());
        vertex_ch.valid <= 1'b0;
        drain();
        configure(2);
        for (int i = 0; i < 5; i++)
            send_vertex(pick16(), pick16(), pick16());
        vertex_ch.valid <= 1'b0;
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 2)
            begin
                tx_idle_pct = 74;
                rx_idle_pct = 17;
            end
            if (phase == 4)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            configure((phase == 3) ? 1 : ((phase == 5) ? 2 : 0));
            for (int i = 0; i < PhaseItems; i++)
                send_vertex(pick16(), pick16(), pick16());
            vertex_ch.valid <= 1'b0;
            drain();
        end

        $display("Sent %0d vertices across %0d register writes, idle mixes and extreme settings.",
                 vertex_count, config_count);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/vtp_pkg.sv
rtl/core/vtp_if.sv
rtl/core/vtp_divider.sv
rtl/core/vertex_transform_project_top.sv
verif/vtp_checker.sv
verif/tb.sv
